/* rtl/lzfs_pkg.sv */
// Shared types, constants and helpers of the LED zone frame serializer.
package lzfs_pkg;

    localparam int WORD_W  = 12;
    localparam int COLOR_W = 3 * WORD_W;
    localparam int MODE_W  = 2;
    localparam int ZONE_W  = 4;

    localparam int DEF_ZONES_PER_CHIP = 5;
    localparam int DEF_CHIPS          = 2;
    localparam int DEF_NUM_ZONES      = 10;

    // A frame is cut after this many words.
    localparam int MAX_WORDS = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [WORD_W-1:0] WORD_MASK = 12'hFFF;
    localparam logic [WORD_W-1:0] PAD_WORD  = 12'h000;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE_ONE    = 2'd0,
        MODE_WRITE_ALL    = 2'd1,
        MODE_CLEAR_UPDATE = 2'd2,
        MODE_UPDATE       = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        SEL_PAD,
        SEL_BLUE,
        SEL_RED,
        SEL_GREEN
    } t_word_sel;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // Colors are packed as {red, green, blue}.
    typedef struct packed {
        t_mode                mode;
        logic [ZONE_W-1:0]    zone;
        logic [COLOR_W-1:0]   color;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

    function automatic logic [WORD_W-1:0] pick_word(input logic [COLOR_W-1:0] color,
                                                    input t_word_sel sel);
        logic [WORD_W-1:0] w;
        unique case (sel)
            SEL_PAD:   w = PAD_WORD;
            SEL_BLUE:  w = color[WORD_W-1:0];
            SEL_RED:   w = color[3*WORD_W-1:2*WORD_W];
            SEL_GREEN: w = color[2*WORD_W-1:WORD_W];
        endcase
        return w & WORD_MASK;
    endfunction

endpackage

/* rtl/lzfs_cmd_if.sv */
// Command channel: one item is one command with its zone and color.
interface lzfs_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [lzfs_pkg::MODE_W-1:0]   mode;
    logic [lzfs_pkg::ZONE_W-1:0]   zone;
    logic [lzfs_pkg::WORD_W-1:0]   red;
    logic [lzfs_pkg::WORD_W-1:0]   green;
    logic [lzfs_pkg::WORD_W-1:0]   blue;

    modport source (output valid, mode, zone, red, green, blue, input ready);
    modport sink   (input valid, mode, zone, red, green, blue, output ready);
endinterface

/* rtl/lzfs_word_if.sv */
// Frame channel: one item is one frame word with its latch flag.
interface lzfs_word_if;
    logic                          valid;
    logic                          ready;
    logic [lzfs_pkg::WORD_W-1:0]   word;
    logic                          latch;

    modport source (output valid, word, latch, input ready);
    modport sink   (input valid, word, latch, output ready);
endinterface

/* rtl/led_zone_frame_serializer.sv */
// Top level of the LED zone frame serializer.
//
//   Channel   Dir   Item                               Payload
//   i_cmd     in    one command                        mode, zone, red, green, blue
//   o_frame   out   one frame word                     word, latch
//
// A write command is executed in the idle state of the frame engine; an update
// sends CHIPS * (1 + 3 * ZONES_PER_CHIP) words (at most 32), one per cycle unless
// the output stalls; each word passes the read stage and the output register.
// The word sequencer and the single read port of the zone store set that rate.
// A two-item command queue lets commands be accepted while a frame is sent.
// Synchronous active-low reset clears the store to zero; no clearing pass is needed.
// A stalled output holds its word, and the sequencer and store read stall with it.
module led_zone_frame_serializer #(
    parameter int ZONES_PER_CHIP = lzfs_pkg::DEF_ZONES_PER_CHIP,
    parameter int CHIPS          = lzfs_pkg::DEF_CHIPS,
    parameter int NUM_ZONES      = lzfs_pkg::DEF_NUM_ZONES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lzfs_cmd_if.sink      i_cmd,
    lzfs_word_if.source   o_frame
);

    lzfs_pkg::t_push push;
    lzfs_pkg::t_head head;
    logic            full;
    logic            pop;

    lzfs_front #(
        .NUM_ZONES (NUM_ZONES)
    ) u_front (
        .i_cmd  (i_cmd),
        .i_full (full),
        .o_push (push)
    );

    lzfs_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_head  (head),
        .i_pop   (pop)
    );

    lzfs_back #(
        .ZONES_PER_CHIP (ZONES_PER_CHIP),
        .CHIPS          (CHIPS),
        .NUM_ZONES      (NUM_ZONES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (head),
        .o_q_pop (pop),
        .o_frame (o_frame)
    );

endmodule

/* rtl/lzfs_front.sv */
// Front end: accepts commands, decodes them and drops writes to missing zones.
module lzfs_front #(
    parameter int NUM_ZONES = lzfs_pkg::DEF_NUM_ZONES
) (
    lzfs_cmd_if.sink          i_cmd,
    input  logic              i_full,
    output lzfs_pkg::t_push   o_push
);

    logic            accept;
    logic            drop;
    lzfs_pkg::t_mode mode;

    assign i_cmd.ready = !i_full;
    assign accept      = i_cmd.valid && !i_full;
    assign mode        = lzfs_pkg::t_mode'(i_cmd.mode);

    // A single-zone write beyond the store has no effect, so it never enters the queue.
    always_comb begin
        unique case (mode)
            lzfs_pkg::MODE_WRITE_ONE: drop = !(32'(i_cmd.zone) < NUM_ZONES);
            default:                  drop = 1'b0;
        endcase
    end

    assign o_push.valid     = accept && !drop;
    assign o_push.cmd.mode  = mode;
    assign o_push.cmd.zone  = i_cmd.zone;
    assign o_push.cmd.color = {i_cmd.red, i_cmd.green, i_cmd.blue};

endmodule

/* rtl/lzfs_cmd_fifo.sv */
// Short command queue between the front end and the frame engine.
module lzfs_cmd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lzfs_pkg::t_push   i_push,
    output logic              o_full,
    output lzfs_pkg::t_head   o_head,
    input  logic              i_pop
);

    localparam int DEPTH = lzfs_pkg::QUEUE_DEPTH;
    localparam int PW    = lzfs_pkg::QUEUE_PTR_W;

    lzfs_pkg::t_cmd   r_entry [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [PW:0]      r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full      = (r_cnt == (PW+1)'(DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd  = r_entry[r_rp];

    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_head.valid;

    // The depth is a power of two, so the pointers wrap on their own.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wp] <= i_push.cmd;
        end
    end

endmodule

/* rtl/lzfs_back.sv */
// Frame engine: executes queued commands on the zone store and sends frame words.
module lzfs_back #(
    parameter int ZONES_PER_CHIP = lzfs_pkg::DEF_ZONES_PER_CHIP,
    parameter int CHIPS          = lzfs_pkg::DEF_CHIPS,
    parameter int NUM_ZONES      = lzfs_pkg::DEF_NUM_ZONES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lzfs_pkg::t_head   i_q,
    output logic              o_q_pop,
    lzfs_word_if.source       o_frame
);

    localparam int  WPC      = 1 + 3 * ZONES_PER_CHIP;
    localparam int  TOTAL    = CHIPS * WPC;
    localparam int  EMIT_N   = (TOTAL < lzfs_pkg::MAX_WORDS) ? TOTAL : lzfs_pkg::MAX_WORDS;
    localparam bit  LATCH_ON = (TOTAL <= lzfs_pkg::MAX_WORDS);
    localparam int  POS_W    = $clog2(lzfs_pkg::MAX_WORDS);
    localparam int  SLOTS    = CHIPS * ZONES_PER_CHIP;
    localparam int  ZC_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int  K_W      = (ZONES_PER_CHIP > 1) ? $clog2(ZONES_PER_CHIP) : 1;
    localparam int  AW       = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
    localparam int  CW       = lzfs_pkg::COLOR_W;
    localparam int  WW       = lzfs_pkg::WORD_W;

    localparam logic [ZC_W-1:0]  ZONE_START = ZC_W'((CHIPS - 1) * ZONES_PER_CHIP);
    localparam logic [ZC_W-1:0]  ZONE_BACK  = ZC_W'(2 * ZONES_PER_CHIP - 1);
    localparam logic [K_W-1:0]   K_LAST     = K_W'(ZONES_PER_CHIP - 1);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(EMIT_N - 1);

    lzfs_pkg::t_state    r_state;
    lzfs_pkg::t_state    n_state;

    // Zone store: entries written since the last fill are valid, all others read r_base.
    logic [CW-1:0]        r_mem [NUM_ZONES];
    logic [NUM_ZONES-1:0] r_valid;
    logic [CW-1:0]        r_base;
    logic [CW-1:0]        r_rd_data;

    // Word sequencer.
    lzfs_pkg::t_word_sel  r_sel;
    logic [K_W-1:0]       r_k;
    logic [ZC_W-1:0]      r_zone;
    logic [POS_W-1:0]     r_pos;

    // Read stage.
    logic                 r_s1_valid;
    lzfs_pkg::t_word_sel  r_s1_sel;
    logic                 r_s1_in_range;
    logic                 r_s1_hit;
    logic [CW-1:0]        r_s1_base;
    logic                 r_s1_last;

    // Output register.
    logic                 r_o_valid;
    logic [WW-1:0]        r_o_word;
    logic                 r_o_latch;

    logic                 adv;
    logic                 wr_one;
    logic                 fill;
    logic [CW-1:0]        fill_color;
    logic                 seq_init;
    logic                 issue;
    logic                 last;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic                 in_range;
    logic [CW-1:0]        s1_color;

    assign adv      = !r_o_valid || o_frame.ready;
    assign wr_addr  = AW'(i_q.cmd.zone);
    assign rd_addr  = AW'(r_zone);
    assign in_range = (32'(r_zone) < NUM_ZONES);
    assign s1_color = r_s1_hit ? r_rd_data : r_s1_base;

    assign o_frame.valid = r_o_valid;
    assign o_frame.word  = r_o_word;
    assign o_frame.latch = r_o_latch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lzfs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_q_pop    = 1'b0;
        wr_one     = 1'b0;
        fill       = 1'b0;
        fill_color = i_q.cmd.color;
        seq_init   = 1'b0;
        issue      = 1'b0;
        last       = 1'b0;
        unique case (r_state)
            lzfs_pkg::ST_IDLE: begin
                if (i_q.valid) begin
                    o_q_pop = 1'b1;
                    unique case (i_q.cmd.mode)
                        lzfs_pkg::MODE_WRITE_ONE: begin
                            wr_one = 1'b1;
                        end
                        lzfs_pkg::MODE_WRITE_ALL: begin
                            fill = 1'b1;
                        end
                        lzfs_pkg::MODE_CLEAR_UPDATE: begin
                            fill       = 1'b1;
                            fill_color = '0;
                            seq_init   = 1'b1;
                            n_state    = lzfs_pkg::ST_EMIT;
                        end
                        lzfs_pkg::MODE_UPDATE: begin
                            seq_init = 1'b1;
                            n_state  = lzfs_pkg::ST_EMIT;
                        end
                    endcase
                end
            end
            lzfs_pkg::ST_EMIT: begin
                if (adv) begin
                    issue = 1'b1;
                    if (r_pos == POS_LAST) begin
                        last    = 1'b1;
                        n_state = lzfs_pkg::ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_base  <= '0;
        end else if (fill) begin
            r_valid <= '0;
            r_base  <= fill_color;
        end else if (wr_one) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_one) begin
            r_mem[wr_addr] <= i_q.cmd.color;
        end
        if (issue) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Far chip first; each chip sends a pad word, then blue, red, green per zone.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel  <= lzfs_pkg::SEL_PAD;
            r_k    <= '0;
            r_zone <= ZONE_START;
            r_pos  <= '0;
        end else if (seq_init) begin
            r_sel  <= lzfs_pkg::SEL_PAD;
            r_k    <= '0;
            r_zone <= ZONE_START;
            r_pos  <= '0;
        end else if (issue && !last) begin
            r_pos <= r_pos + POS_W'(1);
            case (r_sel)
                lzfs_pkg::SEL_PAD:  r_sel <= lzfs_pkg::SEL_BLUE;
                lzfs_pkg::SEL_BLUE: r_sel <= lzfs_pkg::SEL_RED;
                lzfs_pkg::SEL_RED:  r_sel <= lzfs_pkg::SEL_GREEN;
                default: begin
                    if (r_k == K_LAST) begin
                        r_k    <= '0;
                        r_sel  <= lzfs_pkg::SEL_PAD;
                        r_zone <= r_zone - ZONE_BACK;
                    end else begin
                        r_k    <= r_k + K_W'(1);
                        r_sel  <= lzfs_pkg::SEL_BLUE;
                        r_zone <= r_zone + ZC_W'(1);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= issue;
            r_o_valid  <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && issue) begin
            r_s1_sel      <= r_sel;
            r_s1_in_range <= in_range;
            r_s1_hit      <= r_valid[rd_addr];
            r_s1_base     <= r_base;
            r_s1_last     <= LATCH_ON && last;
        end
        if (adv && r_s1_valid) begin
            r_o_word  <= r_s1_in_range ? lzfs_pkg::pick_word(s1_color, r_s1_sel)
                                       : lzfs_pkg::PAD_WORD;
            r_o_latch <= r_s1_last;
        end
    end

endmodule

/* rtl/lzfs_checker.sv */
// Port-level checks of the LED zone frame serializer, bound to the top level.
module lzfs_checker #(
    parameter int ZONES_PER_CHIP = lzfs_pkg::DEF_ZONES_PER_CHIP,
    parameter int CHIPS          = lzfs_pkg::DEF_CHIPS
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [lzfs_pkg::WORD_W-1:0]  i_out_word,
    input logic                         i_out_latch
);

    localparam int  TOTAL    = CHIPS * (1 + 3 * ZONES_PER_CHIP);
    localparam bit  LATCH_ON = (TOTAL <= lzfs_pkg::MAX_WORDS);
    localparam int  CNT_W    = $clog2(lzfs_pkg::MAX_WORDS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TOTAL - 1);

    logic             out_acc;
    logic             r_first;
    logic [CNT_W-1:0] r_cnt;

    assign out_acc = i_out_valid && i_out_ready;

    // Tracks the position of each delivered word within its frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
            r_cnt   <= '0;
        end else if (out_acc) begin
            r_first <= i_out_latch;
            r_cnt   <= i_out_latch ? '0 : r_cnt + CNT_W'(1);
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_word) && $stable(i_out_latch))
        else $error("stalled frame word changed");

    a_pad_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_first |-> i_out_word == lzfs_pkg::PAD_WORD && !i_out_latch)
        else $error("frame does not open with a pad word");

    a_latch_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && LATCH_ON |-> (i_out_latch == (r_cnt == CNT_LAST)))
        else $error("latch flag not on the last word of the frame");

endmodule

bind led_zone_frame_serializer lzfs_checker #(
    .ZONES_PER_CHIP (ZONES_PER_CHIP),
    .CHIPS          (CHIPS)
) u_lzfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_frame.valid),
    .i_out_ready (o_frame.ready),
    .i_out_word  (o_frame.word),
    .i_out_latch (o_frame.latch)
);

/* tb/lzfs_frame_checker.sv */
// Checker that watches both channels, predicts the frame words and compares them.
module lzfs_frame_checker #(
    parameter int ZONES_PER_CHIP = lzfs_pkg::DEF_ZONES_PER_CHIP,
    parameter int CHIPS          = lzfs_pkg::DEF_CHIPS,
    parameter int NUM_ZONES      = lzfs_pkg::DEF_NUM_ZONES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lzfs_cmd_if  i_cmd,
    lzfs_word_if i_frame,
    output int   o_fail_count,
    output int   o_words_pending
);
    import lzfs_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] red;
        logic [WORD_W-1:0] green;
        logic [WORD_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              latch;
    } t_frame_word;

    t_rgb        zone_colors [NUM_ZONES];
    t_frame_word frame_words_due [$];
    t_frame_word oldest_due;
    int          mismatches = 0;

    initial begin
        o_fail_count    = 0;
        o_words_pending = 0;
    end

    function automatic void flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $time, msg);
    endfunction

    // Far chip first; each chip sends a pad word, then blue, red, green per zone.
    function automatic void queue_frame_words();
        int                total;
        int                pos;
        int                z;
        t_rgb              rgb;
        logic [WORD_W-1:0] w;
        total = CHIPS * (1 + 3 * ZONES_PER_CHIP);
        pos   = 0;
        for (int chip = CHIPS - 1; chip >= 0; chip--) begin
            for (int slot = 0; slot <= 3 * ZONES_PER_CHIP; slot++) begin
                if (slot == 0) begin
                    w = PAD_WORD;
                end else begin
                    z   = chip * ZONES_PER_CHIP + (slot - 1) / 3;
                    rgb = (z < NUM_ZONES) ? zone_colors[z] : '0;
                    case ((slot - 1) % 3)
                        0:       w = rgb.blue;
                        1:       w = rgb.red;
                        default: w = rgb.green;
                    endcase
                end
                // A long frame is cut; the latch goes only on its true last word, so a cut frame has none.
                if (pos < MAX_WORDS)
                    frame_words_due.push_back('{word: w, latch: (pos == total - 1)});
                pos++;
            end
        end
    endfunction

    function automatic void apply_command(t_mode mode, logic [ZONE_W-1:0] zone, t_rgb rgb);
        case (mode)
            MODE_WRITE_ONE: begin
                if (zone < NUM_ZONES)
                    zone_colors[zone] = rgb;
            end
            MODE_WRITE_ALL: begin
                foreach (zone_colors[i]) zone_colors[i] = rgb;
            end
            MODE_CLEAR_UPDATE: begin
                foreach (zone_colors[i]) zone_colors[i] = '0;
                queue_frame_words();
            end
            default: queue_frame_words();
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (zone_colors[i]) zone_colors[i] = '0;
            frame_words_due.delete();
        end else begin
            if (i_frame.valid && i_frame.ready) begin
                if (frame_words_due.size() == 0) begin
                    flag_mismatch($sformatf("word %h latch %b arrived with nothing expected",
                                            i_frame.word, i_frame.latch));
                end else begin
                    oldest_due = frame_words_due.pop_front();
                    if (i_frame.word !== oldest_due.word)
                        flag_mismatch($sformatf("word expected %h actual %h",
                                                oldest_due.word, i_frame.word));
                    if (i_frame.latch !== oldest_due.latch)
                        flag_mismatch($sformatf("latch expected %b actual %b",
                                                oldest_due.latch, i_frame.latch));
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                apply_command(t_mode'(i_cmd.mode), i_cmd.zone,
                              '{red: i_cmd.red, green: i_cmd.green, blue: i_cmd.blue});
        end
        o_fail_count    <= mismatches;
        o_words_pending <= frame_words_due.size();
    end

endmodule

/* tb/tb.sv */
// Testbench top: clock, reset, command stimulus, frame receiver and the verdict.
module tb;
    import lzfs_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int STALL_CYCLES = 400;
    localparam int RANDOM_ITEMS = 360;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic tx_idle = 1'b1;
    logic rx_idle;
    logic stall_req;
    logic stall_done = 1'b0;
    int   fail_count;
    int   words_pending;
    int   cycle_count = 0;

    lzfs_cmd_if  cmd_bus ();
    lzfs_word_if frame_bus ();

    led_zone_frame_serializer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_frame (frame_bus)
    );

    lzfs_frame_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd_bus),
        .i_frame         (frame_bus),
        .o_fail_count    (fail_count),
        .o_words_pending (words_pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Frame receiver: random back-pressure, and one long hold-off on request.
    initial begin
        frame_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_req && !stall_done) begin
                frame_bus.ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge i_clk);
                stall_done = 1'b1;
            end else begin
                frame_bus.ready <= !(rx_idle && $urandom_range(0, 99) < 31);
            end
        end
    end

    task automatic send_cmd(input t_mode mode, input logic [ZONE_W-1:0] zone,
                            input logic [WORD_W-1:0] red, input logic [WORD_W-1:0] green,
                            input logic [WORD_W-1:0] blue);
        while (tx_idle && $urandom_range(0, 99) < 31) begin
            cmd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.mode  <= mode;
        cmd_bus.zone  <= zone;
        cmd_bus.red   <= red;
        cmd_bus.green <= green;
        cmd_bus.blue  <= blue;
        do @(posedge i_clk); while (!cmd_bus.ready);
    endtask

    function automatic logic [WORD_W-1:0] pick_level();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return WORD_MASK;
        return WORD_W'($urandom_range(0, 4095));
    endfunction

    // Mostly zone writes and updates; out-of-range zones now and then.
    task automatic send_random_cmd();
        int                pick;
        t_mode             mode;
        logic [ZONE_W-1:0] zone;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            mode = MODE_WRITE_ONE;
        else if (pick < 62)
            mode = MODE_WRITE_ALL;
        else if (pick < 70)
            mode = MODE_CLEAR_UPDATE;
        else
            mode = MODE_UPDATE;
        if ($urandom_range(0, 99) < 85)
            zone = ZONE_W'($urandom_range(0, DEF_NUM_ZONES - 1));
        else
            zone = ZONE_W'($urandom_range(DEF_NUM_ZONES, 15));
        send_cmd(mode, zone, pick_level(), pick_level(), pick_level());
    endtask

    initial begin
        cmd_bus.valid <= 1'b0;
        cmd_bus.mode  <= MODE_WRITE_ONE;
        cmd_bus.zone  <= '0;
        cmd_bus.red   <= '0;
        cmd_bus.green <= '0;
        cmd_bus.blue  <= '0;
        rx_idle       <= 1'b1;
        stall_req     <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty store, extremes, ignored zones, both chips, unused fields.
        send_cmd(MODE_UPDATE,       4'd0,  12'h000, 12'h000, 12'h000);
        send_cmd(MODE_WRITE_ONE,    4'd0,  12'hFFF, 12'hFFF, 12'hFFF);
        send_cmd(MODE_WRITE_ONE,    4'd9,  12'h123, 12'h456, 12'h789);
        send_cmd(MODE_WRITE_ONE,    4'd10, 12'hABC, 12'hDEF, 12'h321);
        send_cmd(MODE_WRITE_ONE,    4'd15, 12'hFFF, 12'hFFF, 12'hFFF);
        send_cmd(MODE_WRITE_ONE,    4'd4,  12'hAAA, 12'h555, 12'hAAA);
        send_cmd(MODE_WRITE_ONE,    4'd5,  12'h555, 12'hAAA, 12'h555);
        send_cmd(MODE_UPDATE,       4'd0,  12'h000, 12'h000, 12'h000);
        send_cmd(MODE_WRITE_ALL,    4'd0,  12'hFFF, 12'hFFF, 12'hFFF);
        send_cmd(MODE_UPDATE,       4'd0,  12'h000, 12'h000, 12'h000);
        send_cmd(MODE_WRITE_ALL,    4'd15, 12'h000, 12'h000, 12'h000);
        send_cmd(MODE_WRITE_ONE,    4'd3,  12'h001, 12'h800, 12'h7FF);
        send_cmd(MODE_UPDATE,       4'd0,  12'h000, 12'h000, 12'h000);
        send_cmd(MODE_CLEAR_UPDATE, 4'd15, 12'hFFF, 12'hFFF, 12'hFFF);
        send_cmd(MODE_WRITE_ONE,    4'd7,  12'hFFF, 12'h000, 12'hFFF);
        send_cmd(MODE_UPDATE,       4'd7,  12'hFFF, 12'hAAA, 12'h555);
        send_cmd(MODE_WRITE_ALL,    4'd2,  12'h800, 12'h001, 12'hF0F);
        send_cmd(MODE_UPDATE,       4'd0,  12'h000, 12'h000, 12'h000);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 120) begin
                tx_idle = 1'b0;
                rx_idle <= 1'b0;
            end
            if (n == 200) begin
                tx_idle = 1'b1;
                rx_idle <= 1'b1;
                stall_req <= 1'b1;
            end
            // Updates right after the hold-off starts fill the block up.
            if (n >= 200 && n < 206)
                send_cmd(MODE_UPDATE, 4'd0, pick_level(), pick_level(), pick_level());
            else
                send_random_cmd();
        end
        cmd_bus.valid <= 1'b0;

        do @(posedge i_clk); while (words_pending != 0);
        repeat (64) @(posedge i_clk);
        if (fail_count == 0 && words_pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
